### src/prq_pkg.sv
// prq_pkg: request/response beat types, request and status codes, and
// the per-cell control encoding for the priority ready queue.
// No dependencies.
package prq_pkg;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_APPEND = 3'd1;
    localparam logic [2:0] REQ_POP    = 3'd2;
    localparam logic [2:0] REQ_REMOVE = 3'd3;
    localparam logic [2:0] REQ_FIND   = 3'd4;
    localparam logic [2:0] REQ_READ   = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [15:0]        proc_id;
        logic signed [15:0] prio;
        logic [4:0]         position;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        out_id;
        logic signed [15:0] out_prio;
        logic [5:0]         occupancy;
    } t_rsp;

    typedef struct packed {
        logic [15:0]        id;
        logic signed [15:0] prio;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // What one cell does at the end of a request.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } t_cell_op;

endpackage

### src/prq_prefix.sv
// prq_prefix: inclusive prefix OR over the cell hit flags, built as a
// log-depth parallel prefix. Depends on nothing.
module prq_prefix #(
    parameter int N = 32
) (
    input  logic [N-1:0] i_bits,
    output logic [N-1:0] o_prefix
);

    localparam int LV = (N > 1) ? $clog2(N) : 1;

    logic [N-1:0] w_lvl [LV+1];

    always_comb begin
        w_lvl[0] = i_bits;
        for (int k = 0; k < LV; k++) begin
            w_lvl[k+1] = w_lvl[k] | (w_lvl[k] << (1 << k));
        end
    end

    assign o_prefix = w_lvl[LV];

endmodule

### src/prq_cell.sv
// prq_cell: one queue slot. Holds an entry, evaluates its hit flag for the
// incoming request and shifts with its neighbors on commit. Uses prq_pkg.
module prq_cell import prq_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic     i_clk,
    input  logic     i_sample,
    input  t_req     i_req,
    input  logic     i_in_range,
    input  t_cell_op i_op,
    input  t_entry   i_new,
    input  t_entry   i_left,
    input  t_entry   i_right,
    output t_entry   o_entry,
    output logic     o_flag
);

    localparam bit         IS_HEAD = (IDX == 0);
    localparam bit         POS_OK  = (IDX < 32);
    localparam logic [4:0] IDX5    = 5'(IDX);

    t_entry r_entry;
    logic   r_flag;
    logic   w_hit;

    always_comb begin
        w_hit = 1'b0;
        case (i_req.req_type)
            REQ_INSERT: begin
                // an empty slot or a higher priority value marks the insert point
                w_hit = !i_in_range || ($signed(r_entry.prio) > $signed(i_req.prio));
            end
            REQ_APPEND:           w_hit = !i_in_range;
            REQ_POP:              w_hit = i_in_range && IS_HEAD;
            REQ_REMOVE, REQ_FIND: w_hit = i_in_range && (r_entry.id == i_req.proc_id);
            REQ_READ:             w_hit = i_in_range && POS_OK && (i_req.position == IDX5);
            default:              w_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_sample) begin
            r_flag <= w_hit;
        end
        case (i_op)
            CELL_LOAD:       r_entry <= i_new;
            CELL_FROM_LEFT:  r_entry <= i_left;
            CELL_FROM_RIGHT: r_entry <= i_right;
            default:         r_entry <= r_entry;
        endcase
    end

    assign o_entry = r_entry;
    assign o_flag  = r_flag;

endmodule

### src/priority_ready_queue.sv
// priority_ready_queue: sorted ready queue built as a row of prq_cell slots.
// Depends on prq_pkg, prq_cell and prq_prefix.
//
// Usage:
//   Request beats enter on i_in_valid/o_in_ready (t_req), one response beat
//   leaves on o_out_valid/i_out_ready (t_rsp) for every request.
//   Insert keeps ascending priority, equal priorities in arrival order;
//   append adds at the tail. Insert/append, pop, remove, find and
//   read-position are supported. In the accept cycle every cell compares
//   its entry with the request and latches a hit flag; in S_EXEC, once the
//   output register is free, a prefix OR over the flags picks the first
//   hit, every cell shifts left, right or holds, and the response is
//   written to the output register. A new request is accepted only in
//   S_IDLE, after the previous one has committed. Reset empties the queue
//   (count zero); slot contents are not cleared. When the receiver stalls,
//   the response holds in the output register, the next request can still
//   be accepted, and it waits in S_EXEC until the output register frees up.
module priority_ready_queue import prq_pkg::*; #(
    parameter int DEPTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state          r_state;
    t_req            r_req;
    t_rsp            r_out;
    logic            r_out_valid;
    logic [CW-1:0]   r_count;

    logic            w_accept;
    logic            w_commit;
    logic [DEPTH-1:0] w_in_range;
    logic [DEPTH-1:0] w_flag;
    logic [DEPTH-1:0] w_pref;
    logic [DEPTH-1:0] w_first;
    t_entry          w_entry [DEPTH];
    t_cell_op        w_op [DEPTH];
    t_entry          w_new;
    logic [ENTRY_W-1:0] w_sel_bits;
    t_entry          w_sel;
    logic            w_any;
    logic            w_grow;
    logic            w_shrink;
    logic            w_give;
    logic [1:0]      w_status;
    logic [CW-1:0]   n_count;
    logic [CW+5:0]   w_occ_wide;
    t_rsp            n_out;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_commit   = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    assign w_new.id   = r_req.proc_id;
    assign w_new.prio = r_req.prio;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_in_range[i] = (CW'(i) < r_count);
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        if (g == 0) begin : g_head
            assign w_left = w_new;
        end else begin : g_body
            assign w_left = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_mid
            assign w_right = w_entry[g+1];
        end
        prq_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_sample   (w_accept),
            .i_req      (i_in_data),
            .i_in_range (w_in_range[g]),
            .i_op       (w_op[g]),
            .i_new      (w_new),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_entry    (w_entry[g]),
            .o_flag     (w_flag[g])
        );
    end

    prq_prefix #(
        .N(DEPTH)
    ) u_prefix (
        .i_bits   (w_flag),
        .o_prefix (w_pref)
    );

    assign w_first = w_flag & ~{w_pref[DEPTH-2:0], 1'b0};
    assign w_any   = w_pref[DEPTH-1];

    // OR together the one-hot selected entry.
    always_comb begin
        w_sel_bits = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_sel_bits = w_sel_bits | (w_entry[i] & {ENTRY_W{w_first[i]}});
        end
    end
    assign w_sel = t_entry'(w_sel_bits);

    always_comb begin
        w_status = ST_OK;
        w_grow   = 1'b0;
        w_shrink = 1'b0;
        w_give   = 1'b0;
        case (r_req.req_type)
            REQ_INSERT, REQ_APPEND: begin
                if (r_count == CW'(DEPTH)) begin
                    w_status = ST_FULL;
                end else begin
                    w_grow = 1'b1;
                end
            end
            REQ_POP: begin
                if (!w_any) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_shrink = 1'b1;
                    w_give   = 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (!w_any) begin
                    w_status = ST_NOTFOUND;
                end else begin
                    w_shrink = 1'b1;
                    w_give   = 1'b1;
                end
            end
            REQ_FIND: begin
                if (!w_any) begin
                    w_status = ST_NOTFOUND;
                end else begin
                    w_give = 1'b1;
                end
            end
            REQ_READ: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else if (!w_any) begin
                    w_status = ST_NOTFOUND;
                end else begin
                    w_give = 1'b1;
                end
            end
            default: w_status = ST_OK;
        endcase
    end

    // Insert/append: the first flagged cell loads, the cells behind it take from
    // the left. Pop/remove: from the hit onward take from the right.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_op[i] = CELL_HOLD;
            if (w_commit && w_grow) begin
                if (w_first[i]) begin
                    w_op[i] = CELL_LOAD;
                end else if (w_pref[i]) begin
                    w_op[i] = CELL_FROM_LEFT;
                end
            end else if (w_commit && w_shrink) begin
                if (w_pref[i]) begin
                    w_op[i] = CELL_FROM_RIGHT;
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_grow) begin
            n_count = r_count + CW'(1);
        end else if (w_shrink) begin
            n_count = r_count - CW'(1);
        end
        w_occ_wide       = (CW + 6)'(n_count);
        n_out.status     = w_status;
        n_out.out_id     = w_give ? w_sel.id : 16'd0;
        n_out.out_prio   = w_give ? w_sel.prio : 16'sd0;
        n_out.occupancy  = w_occ_wide[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req   <= i_in_data;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_commit) begin
                        r_count <= n_count;
                        r_out   <= n_out;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### src/prq_checker.sv
// prq_checker: port-level assertions for priority_ready_queue, bound to
// the top level below. Uses prq_pkg.
module prq_checker import prq_pkg::*; #(
    parameter int DEPTH = 32
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_req i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_rsp o_out_data
);

    // One request in flight at a time: a beat taken drops ready next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after an accepted beat");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |->
            o_out_data.out_id == 16'd0 && o_out_data.out_prio == 16'sd0)
        else $error("non-ok response carries an entry");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_FULL |->
            o_out_data.occupancy == 6'(DEPTH))
        else $error("full status with occupancy below depth");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (DEPTH < 64) |-> o_out_data.occupancy <= 6'(DEPTH))
        else $error("occupancy beyond depth");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled response beat changed");

endmodule

bind priority_ready_queue prq_checker #(.DEPTH(DEPTH)) u_prq_checker (.*);

### test/tb_priority_ready_queue.sv
// tb_priority_ready_queue: self-checking bench for the sorted ready queue.
// Drives request beats, predicts every response from a local copy of the
// queue and compares each response beat. Depends on prq_pkg and the RTL.
module tb_priority_ready_queue;
    import prq_pkg::*;

    localparam int DEPTH           = 32;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_ITEMS    = 1600;
    localparam int RANDOM_PHASES   = 16;
    localparam int DRAIN_TAIL      = 8;

    // Request codes the block ignores.
    localparam logic [2:0] REQ_RSVD_LO = 3'd6;
    localparam logic [2:0] REQ_RSVD_HI = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_req i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_rsp o_out_data;

    t_entry      ready_list[$];
    t_rsp        awaited_rsp[$];
    int unsigned mismatch_count = 0;
    int unsigned rsp_beats = 0;
    bit          no_idle = 1'b0;
    bit          hold_off_req = 1'b0;

    priority_ready_queue #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one accepted request to the local queue and return its response.
    function automatic t_rsp apply_request(input t_req req);
        t_rsp   rsp;
        t_entry ent;
        int     idx;
        rsp = '0;
        rsp.status = ST_OK;
        case (req.req_type)
            REQ_INSERT, REQ_APPEND: begin
                if (ready_list.size() >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    idx = ready_list.size();
                    if (req.req_type == REQ_INSERT) begin
                        // go behind every entry of equal or lower priority
                        idx = 0;
                        while (idx < ready_list.size() &&
                               $signed(ready_list[idx].prio) <= $signed(req.prio))
                            idx++;
                    end
                    ent.id   = req.proc_id;
                    ent.prio = req.prio;
                    ready_list.insert(idx, ent);
                end
            end
            REQ_POP: begin
                if (ready_list.size() == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    ent = ready_list.pop_front();
                    rsp.out_id   = ent.id;
                    rsp.out_prio = ent.prio;
                end
            end
            REQ_REMOVE, REQ_FIND: begin
                idx = -1;
                for (int i = 0; i < ready_list.size(); i++) begin
                    if (idx < 0 && ready_list[i].id == req.proc_id)
                        idx = i;
                end
                if (idx < 0) begin
                    rsp.status = ST_NOTFOUND;
                end else begin
                    rsp.out_id   = ready_list[idx].id;
                    rsp.out_prio = ready_list[idx].prio;
                    if (req.req_type == REQ_REMOVE)
                        ready_list.delete(idx);
                end
            end
            REQ_READ: begin
                if (ready_list.size() == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (req.position >= ready_list.size()) begin
                    rsp.status = ST_NOTFOUND;
                end else begin
                    rsp.out_id   = ready_list[req.position].id;
                    rsp.out_prio = ready_list[req.position].prio;
                end
            end
            default: ;
        endcase
        rsp.occupancy = 6'(ready_list.size());
        return rsp;
    endfunction

    function automatic t_req make_req(input logic [2:0] kind, input logic [15:0] id,
                                      input logic signed [15:0] prio,
                                      input logic [4:0] pos);
        t_req req;
        req.req_type = kind;
        req.proc_id  = id;
        req.prio     = prio;
        req.position = pos;
        return req;
    endfunction

    // Random request; ids lean on entries already queued so find/remove hit.
    function automatic t_req random_request(input int unsigned grow_pct,
                                            input int unsigned shrink_pct);
        t_req        req;
        int unsigned roll;
        int unsigned pos;
        roll = $urandom_range(99);
        if (roll < 3) begin
            req.req_type = $urandom_range(1) ? REQ_RSVD_HI : REQ_RSVD_LO;
        end else begin
            roll = $urandom_range(99);
            if (roll < grow_pct)
                req.req_type = ($urandom_range(3) != 0) ? REQ_INSERT : REQ_APPEND;
            else if (roll < grow_pct + shrink_pct)
                req.req_type = $urandom_range(1) ? REQ_POP : REQ_REMOVE;
            else
                req.req_type = $urandom_range(1) ? REQ_FIND : REQ_READ;
        end

        roll = $urandom_range(9);
        if (roll < 5 && ready_list.size() != 0)
            req.proc_id = ready_list[$urandom_range(ready_list.size() - 1)].id;
        else if (roll < 8)
            req.proc_id = 16'($urandom_range(15));
        else
            req.proc_id = 16'($urandom());

        roll = $urandom_range(9);
        if (roll < 4)
            req.prio = 16'(int'($urandom_range(8)) - 4);
        else if (roll < 6)
            req.prio = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        else
            req.prio = 16'($urandom());

        if (ready_list.size() != 0 && $urandom_range(9) < 7) begin
            pos = $urandom_range(ready_list.size());
            if (pos > 31)
                pos = 31;
        end else begin
            pos = $urandom_range(31);
        end
        req.position = 5'(pos);
        return req;
    endfunction

    // Starts and ends at a falling edge; valid stays high after the beat.
    task automatic send_request(input t_req req);
        while (!no_idle && $urandom_range(99) < 18) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        awaited_rsp.push_back(apply_request(req));
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (awaited_rsp.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR response %0d: %s got %0h expected %0h", rsp_beats, what, got, want);
        mismatch_count++;
    endtask

    task automatic test_empty_queue();
        send_request(make_req(REQ_POP, 16'h0000, 16'sh0000, 5'd0));
        send_request(make_req(REQ_REMOVE, 16'h0000, 16'sh0000, 5'd0));
        send_request(make_req(REQ_FIND, 16'hFFFF, 16'sh0000, 5'd0));
        send_request(make_req(REQ_READ, 16'h0000, 16'sh0000, 5'd0));
        send_request(make_req(REQ_RSVD_LO, 16'hFFFF, 16'sh7FFF, 5'd31));
        send_request(make_req(REQ_RSVD_HI, 16'hFFFF, 16'sh8000, 5'd31));
        wait_for_drain();
    endtask

    task automatic test_sorted_insert();
        send_request(make_req(REQ_INSERT, 16'h0001, 16'sh0000, 5'd0));
        send_request(make_req(REQ_INSERT, 16'hFFFF, 16'sh7FFF, 5'd0));
        send_request(make_req(REQ_INSERT, 16'h8000, 16'sh8000, 5'd0));
        // tie with the first entry: must land behind it
        send_request(make_req(REQ_INSERT, 16'h1234, 16'sh0000, 5'd0));
        send_request(make_req(REQ_APPEND, 16'h00AA, 16'shFFFF, 5'd0));
        send_request(make_req(REQ_INSERT, 16'h5555, 16'shFFFF, 5'd0));
        send_request(make_req(REQ_READ, 16'h0000, 16'sh0000, 5'd0));
        send_request(make_req(REQ_READ, 16'h0000, 16'sh0000, 5'd5));
        send_request(make_req(REQ_READ, 16'h0000, 16'sh0000, 5'd6));
        send_request(make_req(REQ_READ, 16'h0000, 16'sh0000, 5'd31));
        send_request(make_req(REQ_FIND, 16'h1234, 16'sh0000, 5'd0));
        send_request(make_req(REQ_FIND, 16'h4321, 16'sh0000, 5'd0));
        send_request(make_req(REQ_REMOVE, 16'hFFFF, 16'sh0000, 5'd0));
        send_request(make_req(REQ_REMOVE, 16'hFFFF, 16'sh0000, 5'd0));
        send_request(make_req(REQ_POP, 16'h0000, 16'sh0000, 5'd0));
        send_request(make_req(REQ_POP, 16'h0000, 16'sh0000, 5'd0));
        wait_for_drain();
    endtask

    // Receiver stalls while the sender keeps pushing: the queue goes full.
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        repeat (DEPTH + 8) send_request(random_request(100, 0));
        send_request(make_req(REQ_READ, 16'h0000, 16'sh0000, 5'd31));
        send_request(make_req(REQ_APPEND, 16'hA5A5, 16'sh0001, 5'd0));
        wait_for_drain();
    endtask

    task automatic test_random_mix();
        int unsigned grow_pct;
        int unsigned shrink_pct;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 3)
                0: begin
                    grow_pct   = 65;
                    shrink_pct = 15;
                end
                1: begin
                    grow_pct   = 15;
                    shrink_pct = 65;
                end
                default: begin
                    grow_pct   = 35;
                    shrink_pct = 35;
                end
            endcase
            no_idle = (phase == 5);
            repeat (RANDOM_ITEMS / RANDOM_PHASES)
                send_request(random_request(grow_pct, shrink_pct));
            if (phase % 4 == 3)
                wait_for_drain();
        end
        no_idle = 1'b0;
        wait_for_drain();
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end
            i_out_ready <= no_idle || ($urandom_range(99) >= 18);
        end
    end

    always @(posedge i_clk) begin : check_rsp
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_rsp.size() == 0) begin
                report_mismatch("unexpected beat",
                                {o_out_data.out_id, o_out_data.out_prio}, '0);
            end else begin
                want = awaited_rsp.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch("status", 32'(o_out_data.status), 32'(want.status));
                if (o_out_data.out_id !== want.out_id)
                    report_mismatch("out_id", 32'(o_out_data.out_id), 32'(want.out_id));
                if (o_out_data.out_prio !== want.out_prio)
                    report_mismatch("out_prio", 32'(o_out_data.out_prio),
                                    32'(want.out_prio));
                if (o_out_data.occupancy !== want.occupancy)
                    report_mismatch("occupancy", 32'(o_out_data.occupancy),
                                    32'(want.occupancy));
            end
            rsp_beats++;
        end
    end

    // Abort when neither channel moves a beat for too long.
    initial begin : watchdog
        int unsigned stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_sorted_insert();
        test_backpressure();
        test_random_mix();

        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
